@@ rtl/bmt_pkg.sv @@
`timescale 1ns / 1ps

package bmt_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_ARM    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // operation broadcast to every cell in the accept cycle
  typedef struct packed {
    logic              add;
    logic              remove;
    logic              check;
    logic [ADDR_W-1:0] address;
  } cell_ctrl_t;

  // content one cell hands to its lower neighbor
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [HITS_W-1:0] hits;
  } cell_data_t;

endpackage

@@ rtl/breakpoint_match_table_core.sv @@
`timescale 1ns / 1ps

// Breakpoint match table.
// A command word (cmd_i, address_i) is taken at a rising edge with start_i high
// and busy_o low. busy_o stays low: a new word may be issued every cycle.
// Commands: add an address at the end of the table, remove the first matching
// entry (later entries move down), check a program counter, arm single step.
// Exactly one result per word: valid_o is high for one cycle, the cycle right
// after the accepting edge, with status_o, break_now_o, by_step_o, hit_slot_o
// and hit_total_o. Throughput is one word per cycle.
// The rate is set by the row of MAX_ENTRIES cells: every cell compares its
// stored address in the accept cycle and a first-match chain runs through the
// row, so compare, priority and update all finish in the accept cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (rst_ni low, asynchronous) empties the table and clears the step flag;
// the block takes words in the first cycle after reset is released.

module breakpoint_match_table_core #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bmt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [bmt_pkg::ADDR_W-1:0]   address_i,
  output logic                         valid_o,
  output logic [bmt_pkg::STAT_W-1:0]   status_o,
  output logic                         break_now_o,
  output logic                         by_step_o,
  output logic [bmt_pkg::SLOT_W-1:0]   hit_slot_o,
  output logic [bmt_pkg::HITS_W-1:0]   hit_total_o
);

  logic                          accept;
  logic                          step_armed_q, step_armed_d;
  logic                          full;
  logic                          any_hit;
  bmt_pkg::cell_ctrl_t           ctrl;
  bmt_pkg::cell_data_t           data      [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]          hit_chain;
  logic [MAX_ENTRIES-1:0]        prev_valid;
  logic [MAX_ENTRIES-1:0]        first;
  logic [MAX_ENTRIES-1:0]        valid_vec;
  logic [bmt_pkg::HITS_W-1:0]    total     [MAX_ENTRIES];

  logic                          valid_q;
  bmt_pkg::status_e              status_q, status_d;
  logic                          brk_q, brk_d;
  logic                          step_q, step_d;
  logic [bmt_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [bmt_pkg::HITS_W-1:0]    total_q, total_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign full    = data[MAX_ENTRIES-1].valid;
  assign any_hit = hit_chain[MAX_ENTRIES];

  assign ctrl.add     = accept && (cmd_i == bmt_pkg::CMD_ADD) && !full;
  assign ctrl.remove  = accept && (cmd_i == bmt_pkg::CMD_REMOVE);
  assign ctrl.check   = accept && (cmd_i == bmt_pkg::CMD_CHECK) && !step_armed_q;
  assign ctrl.address = address_i;

  assign data[MAX_ENTRIES] = '0;
  assign hit_chain[0]      = 1'b0;
  assign prev_valid[0]     = 1'b1;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g > 0) begin : g_prev
      assign prev_valid[g] = data[g-1].valid;
    end
    assign valid_vec[g]    = data[g].valid;

    bmt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid[g]),
      .hit_before_i (hit_chain[g]),
      .next_i       (data[g+1]),
      .data_o       (data[g]),
      .hit_after_o  (hit_chain[g+1]),
      .first_o      (first[g]),
      .total_o      (total[g])
    );
  end

  always_comb begin
    status_d     = bmt_pkg::ST_OK;
    brk_d        = 1'b0;
    step_d       = 1'b0;
    slot_d       = '0;
    total_d      = '0;
    step_armed_d = step_armed_q;
    case (cmd_i)
      bmt_pkg::CMD_ADD: begin
        if (full) status_d = bmt_pkg::ST_FULL;
      end
      bmt_pkg::CMD_REMOVE: begin
        if (!any_hit) status_d = bmt_pkg::ST_NOT_FOUND;
      end
      bmt_pkg::CMD_CHECK: begin
        if (step_armed_q) begin
          brk_d        = 1'b1;
          step_d       = 1'b1;
          step_armed_d = 1'b0;
        end else if (any_hit) begin
          brk_d = 1'b1;
          // one-hot select of the first matching cell
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (first[i]) begin
              slot_d  = slot_d | bmt_pkg::SLOT_W'(i);
              total_d = total_d | total[i];
            end
          end
        end
      end
      bmt_pkg::CMD_ARM: begin
        step_armed_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      step_armed_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) step_armed_q <= step_armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      brk_q    <= brk_d;
      step_q   <= step_d;
      slot_q   <= slot_d;
      total_q  <= total_d;
    end
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign break_now_o = brk_q;
  assign by_step_o   = step_q;
  assign hit_slot_o  = slot_q;
  assign hit_total_o = total_q;

  // occupied cells always form a solid run from cell zero
  a_solid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("table fill has a gap");

  a_step_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && by_step_o |-> break_now_o && hit_slot_o == '0 && hit_total_o == '0
                             && !step_armed_q)
    else $error("single-step stop carries entry data or left flag armed");

  a_status_no_break : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != bmt_pkg::ST_OK |-> !break_now_o && !by_step_o)
    else $error("error status together with a break");

  a_full_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == bmt_pkg::CMD_ADD && full |=> valid_o && status_o == bmt_pkg::ST_FULL
                                                   && full)
    else $error("add on full table misreported");

endmodule

@@ rtl/bmt_cell.sv @@
`timescale 1ns / 1ps

module bmt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmt_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         prev_valid_i,
  input  logic                         hit_before_i,
  input  bmt_pkg::cell_data_t          next_i,
  output bmt_pkg::cell_data_t          data_o,
  output logic                         hit_after_o,
  output logic                         first_o,
  output logic [bmt_pkg::HITS_W-1:0]   total_o
);

  logic                         valid_q, valid_d;
  logic [bmt_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [bmt_pkg::HITS_W-1:0]   hits_q, hits_d;
  logic                         match;
  logic                         tail;
  logic                         shift;
  logic [bmt_pkg::HITS_W-1:0]   hits_inc;

  assign match    = valid_q && (addr_q == ctrl_i.address);
  assign first_o  = match && !hit_before_i;
  assign hit_after_o = hit_before_i || match;
  // first empty slot takes the appended word
  assign tail     = !valid_q && prev_valid_i;
  // everything from the first match upward moves down one place
  assign shift    = ctrl_i.remove && hit_after_o;
  assign hits_inc = (hits_q == '1) ? hits_q : hits_q + 1'b1;
  assign total_o  = hits_inc;

  assign data_o.valid   = valid_q;
  assign data_o.address = addr_q;
  assign data_o.hits    = hits_q;

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    hits_d  = hits_q;
    if (ctrl_i.add && tail) begin
      valid_d = 1'b1;
      addr_d  = ctrl_i.address;
      hits_d  = '0;
    end else if (shift) begin
      valid_d = next_i.valid;
      addr_d  = next_i.address;
      hits_d  = next_i.hits;
    end else if (ctrl_i.check && first_o) begin
      hits_d  = hits_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    hits_q <= hits_d;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned POOL_N      = 8;

  typedef struct packed {
    bmt_pkg::status_e           status;
    logic                       brk;
    logic                       by_step;
    logic [bmt_pkg::SLOT_W-1:0] slot;
    logic [bmt_pkg::HITS_W-1:0] total;
  } match_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [bmt_pkg::CMD_W-1:0]  cmd_i;
  logic [bmt_pkg::ADDR_W-1:0] address_i;
  logic                       valid_o;
  logic [bmt_pkg::STAT_W-1:0] status_o;
  logic                       break_now_o;
  logic                       by_step_o;
  logic [bmt_pkg::SLOT_W-1:0] hit_slot_o;
  logic [bmt_pkg::HITS_W-1:0] hit_total_o;

  breakpoint_match_table_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .address_i  (address_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .break_now_o(break_now_o),
    .by_step_o  (by_step_o),
    .hit_slot_o (hit_slot_o),
    .hit_total_o(hit_total_o)
  );

  // shadow copy of the table
  logic [bmt_pkg::ADDR_W-1:0] tbl_addr [MAX_ENTRIES];
  logic [bmt_pkg::HITS_W-1:0] tbl_hits [MAX_ENTRIES];
  int unsigned                tbl_count;
  bit                         step_flag;

  match_result_t              pending_results[$];
  logic [bmt_pkg::ADDR_W-1:0] hot_addr [POOL_N];

  int unsigned n_errors;
  int unsigned n_words, n_adds, n_full, n_removes, n_not_found;
  int unsigned n_checks, n_entry_breaks, n_step_breaks;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb: timeout, %0d results outstanding", pending_results.size());
    $display("tb: done, errors");
    $finish;
  end

  function automatic match_result_t predict_word(input bmt_pkg::cmd_e c,
                                                 input logic [bmt_pkg::ADDR_W-1:0] a);
    match_result_t r;
    bit            found;
    r = '0;
    r.status = bmt_pkg::ST_OK;
    found = 1'b0;
    case (c)
      bmt_pkg::CMD_ADD: begin
        n_adds++;
        if (tbl_count >= MAX_ENTRIES) begin
          r.status = bmt_pkg::ST_FULL;
          n_full++;
        end else begin
          tbl_addr[tbl_count] = a;
          tbl_hits[tbl_count] = '0;
          tbl_count++;
        end
      end
      bmt_pkg::CMD_REMOVE: begin
        n_removes++;
        for (int i = 0; i < tbl_count; i++) begin
          if (!found && tbl_addr[i] == a) begin
            for (int j = i; j + 1 < tbl_count; j++) begin
              tbl_addr[j] = tbl_addr[j+1];
              tbl_hits[j] = tbl_hits[j+1];
            end
            found = 1'b1;
          end
        end
        if (found) tbl_count--;
        else begin
          r.status = bmt_pkg::ST_NOT_FOUND;
          n_not_found++;
        end
      end
      bmt_pkg::CMD_CHECK: begin
        n_checks++;
        if (step_flag) begin
          // armed step wins over any matching entry, counters untouched
          step_flag = 1'b0;
          r.brk = 1'b1;
          r.by_step = 1'b1;
          n_step_breaks++;
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            if (!found && tbl_addr[i] == a) begin
              if (tbl_hits[i] != '1) tbl_hits[i] = tbl_hits[i] + 1'b1;
              r.brk = 1'b1;
              r.slot = i[bmt_pkg::SLOT_W-1:0];
              r.total = tbl_hits[i];
              found = 1'b1;
              n_entry_breaks++;
            end
          end
        end
      end
      default: step_flag = 1'b1;
    endcase
    return r;
  endfunction

  // drives a word and holds it until taken; start stays high on return
  task automatic issue_word(input bmt_pkg::cmd_e c, input logic [bmt_pkg::ADDR_W-1:0] a);
    start_i   <= 1'b1;
    cmd_i     <= c;
    address_i <= a;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_word(c, a));
    n_words++;
  endtask

  task automatic idle_gap(input bit allow_long);
    int unsigned pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else if (pick < 98 || !allow_long) len = $urandom_range(4, 10);
    else len = $urandom_range(20, 40);
    if (len > 0) begin
      start_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_error(input string msg);
    if (n_errors < 10) $display("tb: MISMATCH %s", msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [bmt_pkg::HITS_W-1:0] exp_v,
                             input logic [bmt_pkg::HITS_W-1:0] act_v);
    if (exp_v !== act_v)
      note_error($sformatf("%s: expected %h, got %h", name, exp_v, act_v));
  endtask

  always @(posedge clk_i) begin
    match_result_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        note_error("result word with nothing expected");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", bmt_pkg::HITS_W'(exp_r.status), bmt_pkg::HITS_W'(status_o));
        check_field("break_now", bmt_pkg::HITS_W'(exp_r.brk), bmt_pkg::HITS_W'(break_now_o));
        check_field("by_step", bmt_pkg::HITS_W'(exp_r.by_step), bmt_pkg::HITS_W'(by_step_o));
        check_field("hit_slot", bmt_pkg::HITS_W'(exp_r.slot), bmt_pkg::HITS_W'(hit_slot_o));
        check_field("hit_total", exp_r.total, hit_total_o);
      end
    end
  end

  function automatic logic [bmt_pkg::ADDR_W-1:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  task automatic refresh_pool();
    hot_addr[0] = rand_addr();
    hot_addr[1] = '1;
    hot_addr[2] = '0;
    // near neighbors: one bit off from slot 0
    hot_addr[3] = hot_addr[0] ^ (64'd1 << $urandom_range(0, 63));
    hot_addr[4] = hot_addr[0] ^ (64'd1 << $urandom_range(0, 63));
    for (int k = 5; k < POOL_N; k++) hot_addr[k] = rand_addr();
    if ($urandom_range(0, 1)) hot_addr[1] = rand_addr();
  endtask

  task automatic test_empty_table();
    issue_word(bmt_pkg::CMD_CHECK, '0);
    issue_word(bmt_pkg::CMD_REMOVE, '1);
  endtask

  task automatic test_duplicates_and_step();
    issue_word(bmt_pkg::CMD_ADD, '1);
    issue_word(bmt_pkg::CMD_ADD, '0);
    issue_word(bmt_pkg::CMD_ADD, '1);
    issue_word(bmt_pkg::CMD_CHECK, '1);
    issue_word(bmt_pkg::CMD_ARM, 64'h5a5a_a5a5_0f0f_f0f0);
    issue_word(bmt_pkg::CMD_ARM, '1);
    issue_word(bmt_pkg::CMD_CHECK, '0);
    issue_word(bmt_pkg::CMD_CHECK, '0);
  endtask

  task automatic test_remove_shift();
    issue_word(bmt_pkg::CMD_REMOVE, '1);
    issue_word(bmt_pkg::CMD_CHECK, '1);
    issue_word(bmt_pkg::CMD_REMOVE, 64'h5);
  endtask

  task automatic test_fill_until_full();
    while (tbl_count < MAX_ENTRIES) issue_word(bmt_pkg::CMD_ADD, rand_addr());
    issue_word(bmt_pkg::CMD_ADD, '1);
    issue_word(bmt_pkg::CMD_CHECK, tbl_addr[MAX_ENTRIES-1]);
  endtask

  // weighted command mix; addresses mostly from the hot pool so checks and
  // removes actually hit table entries
  task automatic test_random_traffic(input int unsigned add_w, input int unsigned rem_w,
                                     input int unsigned chk_w, input int unsigned arm_w,
                                     input int unsigned n_items, input bit bursty);
    int unsigned                pick;
    bmt_pkg::cmd_e              c;
    logic [bmt_pkg::ADDR_W-1:0] a;
    refresh_pool();
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, add_w + rem_w + chk_w + arm_w - 1);
      if (pick < add_w) c = bmt_pkg::CMD_ADD;
      else if (pick < add_w + rem_w) c = bmt_pkg::CMD_REMOVE;
      else if (pick < add_w + rem_w + chk_w) c = bmt_pkg::CMD_CHECK;
      else c = bmt_pkg::CMD_ARM;
      if ($urandom_range(0, 99) < 75) a = hot_addr[$urandom_range(0, POOL_N - 1)];
      else a = rand_addr();
      issue_word(c, a);
      if (!bursty) idle_gap(1'b1);
      else if ($urandom_range(0, 31) == 0) idle_gap(1'b0);
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    cmd_i     <= bmt_pkg::CMD_ADD;
    address_i <= '0;
    tbl_count = 0;
    step_flag = 1'b0;
    n_errors = 0;
    n_words = 0; n_adds = 0; n_full = 0; n_removes = 0; n_not_found = 0;
    n_checks = 0; n_entry_breaks = 0; n_step_breaks = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_duplicates_and_step();
    test_remove_shift();
    test_fill_until_full();
    wait_drained();

    test_random_traffic(50, 10, 30, 10, 250, 1'b0);  // grow
    test_random_traffic(10, 10, 70, 10, 250, 1'b1);  // check heavy, back to back
    wait_drained();
    test_random_traffic(10, 60, 25, 5, 250, 1'b0);   // drain
    test_random_traffic(30, 30, 30, 10, 250, 1'b0);  // mixed
    wait_drained();
    test_random_traffic(60, 5, 30, 5, 250, 1'b1);    // sit at full
    test_random_traffic(5, 50, 40, 5, 250, 1'b0);
    test_random_traffic(25, 25, 25, 25, 250, 1'b1);  // heavy arming

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("tb: %0d words: %0d adds (%0d full), %0d removes (%0d not found)",
             n_words, n_adds, n_full, n_removes, n_not_found);
    $display("tb: %0d checks: %0d entry breaks, %0d step breaks, %0d mismatches",
             n_checks, n_entry_breaks, n_step_breaks, n_errors);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
